/* hdl/dbs_pkg.sv */
// Package for the dashboard bar-graph scanner: word types, phase enum,
// limits and LED codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbs_pkg;

    localparam int RPM_OFF_LIMIT  = 1000;
    localparam int RPM_TOP_LIMIT  = 3400;
    localparam int RPM_BASE       = 800;
    localparam int RPM_STEP       = 200;
    localparam int RPM_STEP_COUNT = 13;
    localparam int SPEED_STEP     = 5;
    localparam int SPEED_MAX_BARS = 12;
    localparam int RPM_MAX_BARS   = 14;
    localparam int GAS_CODE_BASE  = 13;
    localparam int GAS_EMPTY_CODE = 12;
    localparam int GAS_HIGH_CODE  = 14;
    localparam int GAS_LOW_SLOTS  = 3;
    localparam int BATT_WARN_CODE = 15;

    localparam logic [7:0] PERIOD_RESET    = 8'd120;
    localparam logic [2:0] BATT_WARN_RESET = 3'd2;

    // configuration register indexes
    localparam logic CFG_REFRESH_PERIOD = 1'b0;
    localparam logic CFG_BATT_WARN      = 1'b1;

    // port select codes
    localparam logic PORT_B = 1'b0;
    localparam logic PORT_A = 1'b1;

    typedef enum logic [1:0] {
        PH_SPEED = 2'd0,
        PH_RPM   = 2'd1,
        PH_GAS   = 2'd2,
        PH_BATT  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] rpm;
        logic [7:0]  speed;
        logic [2:0]  gas_level;
        logic [2:0]  battery_level;
        logic        auto_mode;
    } t_in_word;

    typedef struct packed {
        logic       display_on;
        logic       strobe_res;
        logic       port_select;
        logic [3:0] led_code;
    } t_out_word;

endpackage

`default_nettype wire

/* hdl/dbs_bar_calc.sv */
// Bar counts for speed and rpm from raw readings, by parallel threshold compares.
// Depends on dbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbs_bar_calc (
    input  wire logic [15:0] i_rpm,
    input  wire logic [7:0]  i_speed,
    output logic [3:0]       o_speed_bars,
    output logic [3:0]       o_rpm_bars
);
    import dbs_pkg::*;

    logic [SPEED_MAX_BARS-1:0] speed_thr;
    logic [RPM_STEP_COUNT-1:0] rpm_thr;

    // thermometer codes: speed >= 5*k, rpm >= 800 + 200*k
    always_comb begin
        for (int i = 0; i < SPEED_MAX_BARS; i++) begin
            speed_thr[i] = ({1'b0, i_speed} >= 9'(SPEED_STEP * (i + 1)));
        end
        for (int i = 0; i < RPM_STEP_COUNT; i++) begin
            rpm_thr[i] = (i_rpm >= 16'(RPM_BASE + RPM_STEP * (i + 1)));
        end
    end

    always_comb begin
        o_speed_bars = 4'($countones(speed_thr));
        if (i_rpm < 16'(RPM_OFF_LIMIT)) begin
            o_rpm_bars = 4'd0;
        end else if (i_rpm > 16'(RPM_TOP_LIMIT)) begin
            o_rpm_bars = 4'(RPM_MAX_BARS);
        end else begin
            o_rpm_bars = 4'($countones(rpm_thr)) + 4'd1;
        end
    end

endmodule

`default_nettype wire

/* hdl/dashboard_bargraph_scanner.sv */
// Dashboard bar-graph scanner top level: refresh counter, latched bars,
// four-phase LED scanner and output register. Depends on dbs_pkg, dbs_bar_calc.
// Result is registered: valid in the cycle after input accept.
// Throughput: one word per cycle while the output is taken; input ready follows the output register.
// Reset (synchronous, active low): phase speed, counters and bars zero,
// refresh period 120, battery warn level 2, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module dashboard_bargraph_scanner (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dbs_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output dbs_pkg::t_out_word     o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [7:0]        i_cfg_data
);
    import dbs_pkg::*;

    logic [7:0] r_refresh_period;
    logic [2:0] r_batt_warn;
    t_phase     r_phase,        n_phase;
    logic [7:0] r_refresh_count, n_refresh_count;
    logic [3:0] r_led_index,    n_led_index;
    logic [3:0] r_speed_bars,   n_speed_bars;
    logic [3:0] r_rpm_bars,     n_rpm_bars;
    logic [2:0] r_gas_bars,     n_gas_bars;
    logic [2:0] r_batt_bars,    n_batt_bars;
    logic       r_out_valid;
    t_out_word  r_out_data,     n_out_data;

    logic       accept;
    logic       active;
    logic       reload;
    logic [3:0] calc_speed_bars;
    logic [3:0] calc_rpm_bars;

    dbs_bar_calc u_bar_calc (
        .i_rpm        (i_in_data.rpm),
        .i_speed      (i_in_data.speed),
        .o_speed_bars (calc_speed_bars),
        .o_rpm_bars   (calc_rpm_bars)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        active = !(i_in_data.auto_mode && (i_in_data.rpm < 16'(RPM_OFF_LIMIT)));
        reload = (r_refresh_count == r_refresh_period);

        n_refresh_count = reload ? 8'd0 : r_refresh_count + 8'd1;
        n_speed_bars    = r_speed_bars;
        n_rpm_bars      = r_rpm_bars;
        n_gas_bars      = r_gas_bars;
        n_batt_bars     = r_batt_bars;
        if (reload) begin
            n_speed_bars = calc_speed_bars;
            n_rpm_bars   = calc_rpm_bars;
            n_gas_bars   = i_in_data.gas_level;
            n_batt_bars  = i_in_data.battery_level;
        end

        n_phase     = r_phase;
        n_led_index = r_led_index;
        n_out_data  = '0;
        n_out_data.display_on = 1'b1;

        case (r_phase)
            PH_SPEED: begin
                if (r_led_index < n_speed_bars) begin
                    n_out_data.strobe_res  = 1'b1;
                    n_out_data.port_select = PORT_B;
                    n_out_data.led_code    = r_led_index;
                    n_led_index            = r_led_index + 4'd1;
                end else begin
                    n_led_index = 4'd1;
                    n_phase     = PH_RPM;
                end
            end
            PH_RPM: begin
                if (n_rpm_bars == 4'd0) begin
                    n_out_data.strobe_res  = 1'b1;
                    n_out_data.port_select = PORT_A;
                    n_led_index            = 4'd0;
                    n_phase                = PH_GAS;
                end else if (r_led_index < n_rpm_bars) begin
                    n_out_data.strobe_res  = 1'b1;
                    n_out_data.port_select = PORT_A;
                    n_out_data.led_code    = r_led_index;
                    n_led_index            = r_led_index + 4'd1;
                end else begin
                    n_led_index = 4'd0;
                    n_phase     = PH_GAS;
                end
            end
            PH_GAS: begin
                if (n_gas_bars == 3'd0) begin
                    n_out_data.strobe_res  = 1'b1;
                    n_out_data.port_select = PORT_B;
                    n_out_data.led_code    = 4'(GAS_EMPTY_CODE);
                    n_phase                = PH_BATT;
                end else if (r_led_index < {1'b0, n_gas_bars}) begin
                    n_out_data.strobe_res = 1'b1;
                    if (r_led_index < 4'(GAS_LOW_SLOTS)) begin
                        n_out_data.port_select = PORT_B;
                        n_out_data.led_code    = r_led_index + 4'(GAS_CODE_BASE);
                    end else begin
                        n_out_data.port_select = PORT_A;
                        n_out_data.led_code    = 4'(GAS_HIGH_CODE);
                    end
                    n_led_index = r_led_index + 4'd1;
                end else begin
                    n_led_index = 4'd0;
                    n_phase     = PH_BATT;
                end
            end
            PH_BATT: begin
                if (n_batt_bars <= r_batt_warn) begin
                    n_out_data.strobe_res  = 1'b1;
                    n_out_data.port_select = PORT_A;
                    n_out_data.led_code    = 4'(BATT_WARN_CODE);
                end
                n_phase = PH_SPEED;
            end
            default: begin
                n_phase = PH_SPEED;
            end
        endcase

        if (!active) begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh_period <= PERIOD_RESET;
            r_batt_warn      <= BATT_WARN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REFRESH_PERIOD: r_refresh_period <= i_cfg_data;
                CFG_BATT_WARN:      r_batt_warn      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SPEED;
            r_refresh_count <= 8'd0;
            r_led_index     <= 4'd0;
            r_speed_bars    <= 4'd0;
            r_rpm_bars      <= 4'd0;
            r_gas_bars      <= 3'd0;
            r_batt_bars     <= 3'd0;
        end else if (accept && active) begin
            r_phase         <= n_phase;
            r_refresh_count <= n_refresh_count;
            r_led_index     <= n_led_index;
            r_speed_bars    <= n_speed_bars;
            r_rpm_bars      <= n_rpm_bars;
            r_gas_bars      <= n_gas_bars;
            r_batt_bars     <= n_batt_bars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire
